// ----- hdl/frred_pkg.sv -----
package frred_pkg;

  parameter int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [DATA_WIDTH-2:0] mag_t;

  // request to the shared divider
  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  // response from the shared divider
  typedef struct packed {
    logic  done;
    data_t quot;
    data_t rem;
  } div_rsp_t;

endpackage

// ----- hdl/fraction_reducer_core.sv -----
// sequence: setup, then one divider run per euclid remainder step (none for a zero
//   denominator, one for equal magnitudes, up to ~1.44 * DATA_WIDTH), then the two divisions
//   by the gcd; a zero numerator finishes straight from setup
// throughput: one transaction at a time, set by the single shared bit-serial divider that runs
//   every euclid step and both final divisions by the gcd
// reset: rst_ni low clears the sequencer, the divider and the result strobe; the receiver cannot
//   stall, each result shows on done_o for exactly one cycle
module fraction_reducer_core
  import frred_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] num_in_i,
  input  logic signed [DATA_WIDTH-1:0] den_in_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] num_out_o,
  output logic        [DATA_WIDTH-2:0] den_out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_EUC_GO,
    S_EUC_WAIT,
    S_NUM_GO,
    S_NUM_WAIT,
    S_DEN_GO,
    S_DEN_WAIT
  } state_e;

  state_e   state_q;
  data_t    up_q;      // numerator magnitude
  data_t    dn_q;      // denominator magnitude
  logic     neg_q;     // sign of the fraction
  data_t    a_q;       // euclid pair, a_q ends as the gcd
  data_t    b_q;
  data_t    qn_q;      // reduced numerator magnitude
  logic     done_q;
  data_t    num_out_q;
  mag_t     den_out_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // input magnitudes, the most negative value maps to 2^(DATA_WIDTH-1)
  data_t num_mag;
  data_t den_mag;
  assign num_mag = num_in_i[DATA_WIDTH-1] ? (~$unsigned(num_in_i) + data_t'(1))
                                          : $unsigned(num_in_i);
  assign den_mag = den_in_i[DATA_WIDTH-1] ? (~$unsigned(den_in_i) + data_t'(1))
                                          : $unsigned(den_in_i);

  // larger and smaller magnitude seed the euclid loop
  logic  up_ge_dn;
  data_t seed_hi;
  data_t seed_lo;
  assign up_ge_dn = (up_q >= dn_q);
  assign seed_hi  = up_ge_dn ? up_q : dn_q;
  assign seed_lo  = up_ge_dn ? dn_q : up_q;

  // saturate a reduced magnitude into DATA_WIDTH-1 bits
  function automatic mag_t sat_mag(data_t v);
    mag_t r;
    r = v[DATA_WIDTH-1] ? '1 : v[DATA_WIDTH-2:0];
    return r;
  endfunction

  mag_t  num_sat;
  data_t num_ext;
  assign num_sat = sat_mag(qn_q);
  assign num_ext = {1'b0, num_sat};

  // shared divider: euclid remainder, then up / gcd, then down / gcd
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = a_q;
    div_req.divisor  = b_q;
    case (state_q)
      S_EUC_GO: begin
        div_req.start = 1'b1;
      end
      S_NUM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = up_q;
        div_req.divisor  = a_q;
      end
      S_DEN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = dn_q;
        div_req.divisor  = a_q;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  frred_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      up_q      <= '0;
      dn_q      <= '0;
      neg_q     <= 1'b0;
      a_q       <= '0;
      b_q       <= '0;
      qn_q      <= '0;
      done_q    <= 1'b0;
      num_out_q <= '0;
      den_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            up_q    <= num_mag;
            dn_q    <= den_mag;
            neg_q   <= num_in_i[DATA_WIDTH-1] ^ den_in_i[DATA_WIDTH-1];
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (up_q == '0) begin
            // zero numerator always reduces to 0/1
            num_out_q <= '0;
            den_out_q <= mag_t'(1);
            done_q    <= 1'b1;
            state_q   <= S_IDLE;
          end else begin
            a_q <= seed_hi;
            b_q <= seed_lo;
            // zero denominator: the gcd is the numerator itself
            state_q <= (seed_lo == '0) ? S_NUM_GO : S_EUC_GO;
          end
        end
        S_EUC_GO: begin
          state_q <= S_EUC_WAIT;
        end
        S_EUC_WAIT: begin
          if (div_rsp.done) begin
            a_q     <= b_q;
            b_q     <= div_rsp.rem;
            state_q <= (div_rsp.rem == '0) ? S_NUM_GO : S_EUC_GO;
          end
        end
        S_NUM_GO: begin
          state_q <= S_NUM_WAIT;
        end
        S_NUM_WAIT: begin
          if (div_rsp.done) begin
            qn_q    <= div_rsp.quot;
            state_q <= S_DEN_GO;
          end
        end
        S_DEN_GO: begin
          state_q <= S_DEN_WAIT;
        end
        S_DEN_WAIT: begin
          if (div_rsp.done) begin
            // sign goes on the numerator, denominator stays non-negative
            num_out_q <= neg_q ? (~num_ext + data_t'(1)) : num_ext;
            den_out_q <= sat_mag(div_rsp.quot);
            done_q    <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign num_out_o = $signed(num_out_q);
  assign den_out_o = den_out_q;

  // a result strobe only follows work in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a transaction in progress");

  // a result is one cycle wide
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // zero numerator always comes with a unit denominator
  a_zero_over_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && num_out_o == '0) |-> (den_out_o == mag_t'(1)))
    else $error("zero numerator without unit denominator");

  // the divider only answers while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_EUC_WAIT || state_q == S_NUM_WAIT ||
                      state_q == S_DEN_WAIT))
    else $error("divider answer while not waiting");

endmodule

// ----- hdl/frred_div.sv -----
module frred_div
  import frred_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e       state_q;
  logic [CNT_W-1:0] cnt_q;
  data_t            quo_q;
  data_t            rem_q;
  data_t            dvs_q;
  logic             done_q;

  // one restoring step: shift in next dividend bit, try subtract
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH:0] diff;

  assign trial = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        DIV_IDLE: begin
          if (req_i.start) begin
            quo_q   <= req_i.dividend;
            dvs_q   <= req_i.divisor;
            rem_q   <= '0;
            cnt_q   <= CNT_W'(DATA_WIDTH);
            state_q <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (diff[DATA_WIDTH]) begin
            rem_q <= trial[DATA_WIDTH-1:0];
          end else begin
            rem_q <= diff[DATA_WIDTH-1:0];
          end
          quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end
        end
        default: begin
          state_q <= DIV_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  // remainder is always reduced below a nonzero divisor
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  // done comes only at the end of a run
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == DIV_RUN)
    else $error("divider done without a run");

endmodule

// ----- tb/sv/fraction_reducer_core_checker.sv -----
`timescale 1ns / 1ps

module fraction_reducer_core_checker
  import frred_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  busy_i,
  input  data_t num_in_i,
  input  data_t den_in_i,
  input  logic  done_i,
  input  data_t num_out_i,
  input  mag_t  den_out_i,
  output int    mismatches_o,
  output int    outstanding_o,
  output int    checked_o
);

  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    data_t num;
    mag_t  den;
  } fraction_t;

  fraction_t reduced_q[$];
  int        mismatch_cnt = 0;
  int        checked_cnt  = 0;

  assign mismatches_o = mismatch_cnt;
  assign checked_o    = checked_cnt;

  // lowest terms of n/d, sign on the numerator, magnitudes saturated to the positive max
  function automatic fraction_t reduce_fraction(data_t n, data_t d);
    data_t     up;
    data_t     down;
    data_t     a;
    data_t     b;
    data_t     t;
    data_t     lim;
    logic      neg;
    fraction_t r;
    lim  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    neg  = n[DATA_WIDTH-1] ^ d[DATA_WIDTH-1];
    up   = n[DATA_WIDTH-1] ? -n : n;
    down = d[DATA_WIDTH-1] ? -d : d;
    if (up == '0) begin
      down = data_t'(1);
      neg  = 1'b0;
    end else begin
      a = (up >= down) ? up : down;
      b = (up >= down) ? down : up;
      while (b != '0) begin
        t = a % b;
        a = b;
        b = t;
      end
      up   = up / a;
      down = down / a;
    end
    if (up > lim) up = lim;
    if (down > lim) down = lim;
    r.num = neg ? -up : up;
    r.den = down[DATA_WIDTH-2:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    fraction_t exp_frac;
    if (rst_ni) begin
      if (start_i && !busy_i) reduced_q.push_back(reduce_fraction(num_in_i, den_in_i));
      if (done_i) begin
        if (reduced_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no transaction pending",
                                    $signed(num_out_i), den_out_i));
        end else begin
          exp_frac = reduced_q.pop_front();
          checked_cnt++;
          if (num_out_i !== exp_frac.num)
            report_mismatch($sformatf("num_out %0d, expected %0d",
                                      $signed(num_out_i), $signed(exp_frac.num)));
          if (den_out_i !== exp_frac.den)
            report_mismatch($sformatf("den_out %0d, expected %0d", den_out_i, exp_frac.den));
        end
      end
    end
    outstanding_o <= reduced_q.size();
  end

endmodule

// ----- tb/sv/fraction_reducer_core_tb.sv -----
`timescale 1ns / 1ps

module fraction_reducer_core_tb;
  import frred_pkg::*;

  // stimulus sizing
  localparam int RANDOM_ITEMS = 676;
  // longest euclid run is ~1.44 * DATA_WIDTH divider steps
  localparam int TAIL_CYCLES  = 2000;
  // no transaction for this long means the block is hung
  localparam int STALL_LIMIT  = 20000;

  localparam data_t MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] num_in = '0;
  logic signed [DATA_WIDTH-1:0] den_in = '0;
  logic                         done;
  logic signed [DATA_WIDTH-1:0] num_out;
  logic        [DATA_WIDTH-2:0] den_out;

  int mismatches;
  int outstanding;
  int checked;
  int sent_cnt     = 0;
  int directed_cnt = 0;
  int quiet_cycles = 0;

  fraction_reducer_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .num_in_i (num_in),
    .den_in_i (den_in),
    .done_o   (done),
    .num_out_o(num_out),
    .den_out_o(den_out)
  );

  // watches both channels, predicts each reduced fraction and compares
  fraction_reducer_core_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .num_in_i     (num_in),
    .den_in_i     (den_in),
    .done_i       (done),
    .num_out_i    (num_out),
    .den_out_i    (den_out),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: restarts on every accepted transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results still pending",
                 STALL_LIMIT, outstanding);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // present one fraction and hold it until the block takes it; start stays high on return
  // so a following back-to-back transaction does not toggle it within one step
  task automatic send_fraction(input data_t n, input data_t d);
    start  <= 1'b1;
    num_in <= n;
    den_in <= d;
    do @(posedge clk_i); while (busy);
    sent_cnt++;
  endtask

  // sender drops start and drives junk on the data ports while it waits out the gap
  task automatic idle_gap(input int n);
    if (n > 0) begin
      start  <= 1'b0;
      num_in <= $urandom;
      den_in <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold off until every predicted result has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    data_t       n;
    data_t       d;
    int unsigned g;
    int unsigned a;
    int unsigned b;
    int          burst_left;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zeros, signs, extremes, the longest euclid chain and saturation
    send_fraction(0, 0);                       // zero over zero
    send_fraction(0, 5);                       // zero numerator
    send_fraction(0, -7);                      // zero numerator, negative denominator
    send_fraction(5, 0);                       // zero denominator, positive
    send_fraction(-5, 0);                      // zero denominator, negative
    send_fraction(1, 1);
    send_fraction(-1, -1);
    send_fraction(6, 4);
    send_fraction(-6, 4);
    send_fraction(6, -4);
    send_fraction(-6, -4);
    send_fraction(12, 12);                     // equal magnitudes
    send_fraction(MAX_POS, MAX_POS);
    send_fraction(MAX_POS, -MAX_POS);
    send_fraction(-MAX_POS, 1);
    send_fraction(1, -MAX_POS);
    send_fraction(MAX_POS, 2);
    send_fraction(32'sd1836311903, 32'sd1134903170); // consecutive fibonacci, most steps
    send_fraction(MOST_NEG, 2);                // most negative input, reduces in range
    send_fraction(MOST_NEG, 3);                // most negative input, saturates
    send_fraction(3, MOST_NEG);
    send_fraction(MOST_NEG, MOST_NEG);
    send_fraction(MOST_NEG, 0);
    send_fraction(0, MOST_NEG);
    directed_cnt = sent_cnt;

    wait_for_drain();

    // random: full range, small values, shared factors, zeros and equal magnitudes
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        case ($urandom_range(0, 3))
          0:       idle_gap(0);
          1:       idle_gap($urandom_range(1, 8));
          2:       idle_gap($urandom_range(1, 60));
          default: idle_gap($urandom_range(60, 600));
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom;
          d = $urandom;
        end
        3, 4: begin
          n = data_t'(int'($urandom_range(0, 2000)) - 1000);
          d = data_t'(int'($urandom_range(0, 2000)) - 1000);
        end
        5, 6, 7: begin
          // common factor so the gcd is large
          g = $urandom_range(1, 65535);
          a = $urandom_range(0, 32767);
          b = $urandom_range(1, 32767);
          n = a * g;
          d = b * g;
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end
        8: begin
          n = $urandom;
          d = $urandom;
          if ($urandom_range(0, 1)) n = '0;
          else d = '0;
        end
        default: begin
          d = $urandom;
          n = $urandom_range(0, 1) ? d : -d;
        end
      endcase
      send_fraction(n, d);
      burst_left--;
    end

    wait_for_drain();
    idle_gap(TAIL_CYCLES);

    $display("covered %0d fractions (%0d directed: zeros, signs, extremes, saturation),",
             sent_cnt, directed_cnt);
    $display("random mix of full range, small and common factor operands; %0d results compared",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/frred_pkg.sv
hdl/frred_div.sv
hdl/fraction_reducer_core.sv
tb/sv/fraction_reducer_core_checker.sv
tb/sv/fraction_reducer_core_tb.sv
